// ===== src/itf_pkg.sv =====
// Shared types, constants and a function for the integer-to-text formatter.
`default_nettype none
package itf_pkg;

   // Field widths of the request and response items
   localparam int VALUE_W  = 32;
   localparam int RADIX_W  = 6;
   localparam int WIDTH_W  = 6;
   localparam int DIGITS_W = 6;
   localparam int FLAGS_W  = 7;
   localparam int CHAR_W   = 8;

   // Number width taken from the value field, and depth of the digit buffer
   localparam int VALUE_BITS         = 32;
   localparam int DIGIT_BUFFER_DEPTH = 32;

   // Long division: quotient bits resolved per cycle and division steps per digit
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_STEPS     = VALUE_BITS / BITS_PER_STEP;
   localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Digit buffer addressing and digit count
   localparam int DIG_IDX_W = $clog2(DIGIT_BUFFER_DEPTH);
   localparam int DIG_CNT_W = $clog2(DIGIT_BUFFER_DEPTH + 1);

   // Character position within one item's text (at most 64 characters)
   localparam int POS_W     = 7;
   localparam int MAX_CHARS = 64;

   // Radix limits
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
   localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

   // Format flag bit positions
   localparam int FLAG_ZERO   = 0;
   localparam int FLAG_SIGNED = 1;
   localparam int FLAG_PLUS   = 2;
   localparam int FLAG_SPACE  = 3;
   localparam int FLAG_LEFT   = 4;
   localparam int FLAG_PREFIX = 5;
   localparam int FLAG_LOWER  = 6;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UC_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'h78;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // take a request, start the first digit
      logic div_step;  // resolve one slice of quotient bits
      logic setup;     // work out the text layout
      logic emit;      // place the next character in the output register
   } itf_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic req_bad;     // radix of the offered request is out of range
      logic div_finish;  // this division step produces the final digit
      logic emit_last;   // next character is the last of the text
   } itf_status_type;

   // Map a digit value to its ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                    input logic lower);
      logic [CHAR_W-1:0] dd;
      dd = CHAR_W'(d);
      if (d < RADIX_W'(10)) begin
         digit_char = CHAR_ZERO + dd;
      end else if (lower) begin
         digit_char = CHAR_LC_A + dd - CHAR_W'(10);
      end else begin
         digit_char = CHAR_UC_A + dd - CHAR_W'(10);
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/itf_req_if.sv =====
// Request channel of the formatter: handshake and the number with its format.
`default_nettype none
interface itf_req_if;
   import itf_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [RADIX_W-1:0]  radix;
   logic [WIDTH_W-1:0]  text_width;
   logic [DIGITS_W-1:0] min_digits;
   logic [FLAGS_W-1:0]  format_flags;

   modport source (output valid, value, radix, text_width, min_digits, format_flags,
                   input ready);
   modport sink   (input valid, value, radix, text_width, min_digits, format_flags,
                   output ready);
endinterface
`default_nettype wire

// ===== src/itf_rsp_if.sv =====
// Response channel of the formatter: handshake and one text character.
`default_nettype none
interface itf_rsp_if;
   import itf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;
   logic              last_char;
   logic              bad_radix;

   modport source (output valid, text_char, last_char, bad_radix, input ready);
   modport sink   (input valid, text_char, last_char, bad_radix, output ready);
endinterface
`default_nettype wire

// ===== src/itf_datapath.sv =====
// Datapath of the formatter: divider, digit buffer, layout and character output.
`default_nettype none
module itf_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [itf_pkg::VALUE_W-1:0]   req_value,
   input  wire logic [itf_pkg::RADIX_W-1:0]   req_radix,
   input  wire logic [itf_pkg::WIDTH_W-1:0]   req_text_width,
   input  wire logic [itf_pkg::DIGITS_W-1:0]  req_min_digits,
   input  wire logic [itf_pkg::FLAGS_W-1:0]   req_format_flags,
   input  wire itf_pkg::itf_cmd_type          cmd,
   output itf_pkg::itf_status_type            status,
   output logic [itf_pkg::CHAR_W-1:0]         rsp_text_char,
   output logic                               rsp_last_char,
   output logic                               rsp_bad_radix
);
   import itf_pkg::*;

   // Request registers
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [RADIX_W-1:0]    radix_ff;
   logic [WIDTH_W-1:0]    width_ff;
   logic [DIGITS_W-1:0]   prec_ff;
   logic                  zero_ff, left_ff, lower_ff, bad_ff;
   logic                  has_sign_ff;
   logic [CHAR_W-1:0]     sign_char_ff;
   logic [1:0]            pre_ff;

   // Divider registers and digit buffer
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff;
   logic [DIG_CNT_W-1:0]  ndig_ff;
   logic [RADIX_W-1:0]    dig_ff [DIGIT_BUFFER_DEPTH];

   // Layout registers: end of each section of the text
   logic [POS_W-1:0]      end_lead_ff, end_sign_ff, end_pre_ff, end_zeros_ff, end_dig_ff;
   logic [POS_W-1:0]      total_m1_ff, pos_ff;

   // Output register
   logic [CHAR_W-1:0]     out_char_ff;
   logic                  out_last_ff, out_bad_ff;

   // Decoded request
   logic                  req_bad;
   logic                  req_left, req_neg;
   logic [VALUE_BITS-1:0] req_num;

   // Layout terms
   logic [DIGITS_W-1:0]   ndig_w, maxp;
   logic [POS_W-1:0]      others, pad, lead, zpad, trail;
   logic [POS_W-1:0]      e_lead, e_sign, e_pre, e_zeros, e_dig, total;

   // Character selection
   logic [POS_W-1:0]      dig_pos;
   logic [CHAR_W-1:0]     next_char;
   logic                  take_digit;

   // Decode the offered request
   always_comb begin
      req_bad  = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
      req_left = req_format_flags[FLAG_LEFT];
      req_num  = req_value[VALUE_BITS-1:0];
      req_neg  = req_format_flags[FLAG_SIGNED] && req_num[VALUE_BITS-1];
   end

   // Resolve BITS_PER_STEP quotient bits by restoring division
   always_comb begin
      logic [RADIX_W:0] r_w;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         r_w     = {rem_in, quot_in[VALUE_BITS-1]};
         quot_in = {quot_in[VALUE_BITS-2:0], 1'b0};
         if (r_w >= {1'b0, radix_ff}) begin
            r_w        = r_w - {1'b0, radix_ff};
            quot_in[0] = 1'b1;
         end
         rem_in = r_w[RADIX_W-1:0];
      end
   end

   // Work out where each section of the text ends
   always_comb begin
      ndig_w  = DIGITS_W'(ndig_ff);
      maxp    = (prec_ff > ndig_w) ? prec_ff : ndig_w;
      others  = POS_W'(has_sign_ff) + POS_W'(pre_ff) + POS_W'(maxp);
      pad     = (POS_W'(width_ff) > others) ? POS_W'(width_ff) - others : '0;
      lead    = (!zero_ff && !left_ff) ? pad : '0;
      zpad    = zero_ff ? pad : '0;
      trail   = left_ff ? pad : '0;
      e_lead  = lead;
      e_sign  = e_lead + POS_W'(has_sign_ff);
      e_pre   = e_sign + POS_W'(pre_ff);
      e_zeros = e_pre + zpad + POS_W'(maxp - ndig_w);
      e_dig   = e_zeros + POS_W'(ndig_w);
      total   = e_dig + trail;
   end

   // Pick the character at the current position
   always_comb begin
      dig_pos    = end_dig_ff - POS_W'(1) - pos_ff;
      take_digit = 1'b0;
      if (bad_ff) begin
         next_char = CHAR_NUL;
      end else if (pos_ff < end_lead_ff) begin
         next_char = CHAR_SPACE;
      end else if (pos_ff < end_sign_ff) begin
         next_char = sign_char_ff;
      end else if (pos_ff < end_pre_ff) begin
         if (pos_ff == end_sign_ff) begin
            next_char = CHAR_ZERO;
         end else begin
            next_char = lower_ff ? CHAR_LC_X : CHAR_UC_X;
         end
      end else if (pos_ff < end_zeros_ff) begin
         next_char = CHAR_ZERO;
      end else if (pos_ff < end_dig_ff) begin
         next_char  = CHAR_ZERO;
         take_digit = 1'b1;
      end else begin
         next_char = CHAR_SPACE;
      end
   end

   // Status back to the controller
   always_comb begin
      status.req_bad    = req_bad;
      status.div_finish = (step_ff == STEP_W'(DIV_STEPS - 1)) &&
                          ((quot_in == '0) || (ndig_ff == DIG_CNT_W'(DIGIT_BUFFER_DEPTH - 1)));
      status.emit_last  = (pos_ff == total_m1_ff);
   end

   // Latch the request and prepare the magnitude
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         radix_ff <= req_radix;
         width_ff <= req_text_width;
         prec_ff  <= req_min_digits;
         bad_ff   <= req_bad;
         left_ff  <= req_left;
         zero_ff  <= req_format_flags[FLAG_ZERO] && !req_left;
         lower_ff <= req_format_flags[FLAG_LOWER];
         quot_ff  <= req_neg ? (~req_num + VALUE_BITS'(1)) : req_num;
         if (req_neg) begin
            has_sign_ff  <= 1'b1;
            sign_char_ff <= CHAR_MINUS;
         end else if (req_format_flags[FLAG_PLUS]) begin
            has_sign_ff  <= 1'b1;
            sign_char_ff <= CHAR_PLUS;
         end else if (req_format_flags[FLAG_SPACE]) begin
            has_sign_ff  <= 1'b1;
            sign_char_ff <= CHAR_SPACE;
         end else begin
            has_sign_ff  <= 1'b0;
            sign_char_ff <= CHAR_SPACE;
         end
         if (!req_format_flags[FLAG_PREFIX]) begin
            pre_ff <= 2'd0;
         end else if (req_radix == RADIX_HEX) begin
            pre_ff <= 2'd2;
         end else if (req_radix == RADIX_OCT) begin
            pre_ff <= 2'd1;
         end else begin
            pre_ff <= 2'd0;
         end
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
      end
   end

   // Advance the divider and store each finished digit
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         step_ff <= '0;
         ndig_ff <= '0;
      end else if (cmd.load) begin
         rem_ff  <= '0;
         step_ff <= '0;
         ndig_ff <= '0;
      end else if (cmd.div_step) begin
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            rem_ff  <= '0;
            step_ff <= '0;
            ndig_ff <= ndig_ff + DIG_CNT_W'(1);
         end else begin
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // Digit buffer, least significant digit first
   always_ff @(posedge clock) begin
      if (cmd.div_step && (step_ff == STEP_W'(DIV_STEPS - 1))) begin
         dig_ff[ndig_ff[DIG_IDX_W-1:0]] <= rem_in;
      end
   end

   // Hold the layout and step through the text; clip the text at 64 characters
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         total_m1_ff <= '0;
      end else if (cmd.setup) begin
         pos_ff       <= '0;
         end_lead_ff  <= e_lead;
         end_sign_ff  <= e_sign;
         end_pre_ff   <= e_pre;
         end_zeros_ff <= e_zeros;
         end_dig_ff   <= e_dig;
         total_m1_ff  <= bad_ff ? '0 :
                         (total > POS_W'(MAX_CHARS)) ? POS_W'(MAX_CHARS - 1) :
                         total - POS_W'(1);
      end else if (cmd.emit) begin
         pos_ff <= pos_ff + POS_W'(1);
      end
   end

   // Output register; digits are read from the buffer here
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (take_digit) begin
            out_char_ff <= digit_char(dig_ff[dig_pos[DIG_IDX_W-1:0]], lower_ff);
         end else begin
            out_char_ff <= next_char;
         end
         out_last_ff <= status.emit_last;
         out_bad_ff  <= bad_ff;
      end
   end

   assign rsp_text_char = out_char_ff;
   assign rsp_last_char = out_last_ff;
   assign rsp_bad_radix = out_bad_ff;

endmodule
`default_nettype wire

// ===== src/itf_controller.sv =====
// Controller of the formatter: sequences loading, division, layout and output.
`default_nettype none
module itf_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire itf_pkg::itf_status_type  status,
   output itf_pkg::itf_cmd_type          cmd
);
   import itf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_SETUP = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   // Output register can take a character when empty or being drained
   assign out_free = !valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.setup    = 1'b0;
      cmd.emit     = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_bad ? ST_SETUP : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_finish) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on each emitted character, drop once taken
   always_comb begin
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== src/integer_to_text_formatter.sv =====
// Top level of the integer-to-text formatter: controller, datapath and assertions.
`default_nettype none
// Formats one 32-bit integer per request in printf style (base 2 to 36, field width,
// minimum digit count, zero pad, sign, plus, space, left-justify, 0/0x prefix, lower
// case) and returns the text one character per response, the last one marked; text
// beyond 64 characters is dropped and the 64th is marked last. A base outside 2 to 36
// gives a single response with character zero and bad_radix set. A request is accepted,
// the divider resolves its digits (8 quotient bits per cycle over the 32-bit value, 1 to
// 32 digits), the layout is worked out and then the characters (1 to 64) are placed in
// the output register in turn while the response side takes them; a bad base skips the
// divider. The divider loop sets the digit phase; the next request is taken once the last
// character has been placed in the output register.
module integer_to_text_formatter (
   input  wire logic  clock,
   input  wire logic  reset,
   itf_req_if.sink    req_ch,
   itf_rsp_if.source  rsp_ch
);
   import itf_pkg::*;

   itf_cmd_type    cmd;
   itf_status_type status;

   itf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   itf_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_ch.value),
      .req_radix        (req_ch.radix),
      .req_text_width   (req_ch.text_width),
      .req_min_digits   (req_ch.min_digits),
      .req_format_flags (req_ch.format_flags),
      .cmd              (cmd),
      .status           (status),
      .rsp_text_char    (rsp_ch.text_char),
      .rsp_last_char    (rsp_ch.last_char),
      .rsp_bad_radix    (rsp_ch.bad_radix)
   );

`ifndef SYNTHESIS
   // An error response is a single zero character
   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.bad_radix |-> rsp_ch.last_char && (rsp_ch.text_char == CHAR_NUL))
      else $error("error response not a single zero character");

   // A request with a bad radix skips the divider
   a_bad_skips_div: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && status.req_bad |=> cmd.setup)
      else $error("bad radix request did not go straight to layout");

   // Emitting the last character frees the block for the next request
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.emit_last |=> req_ch.ready)
      else $error("block not ready after last character");
`endif

endmodule
`default_nettype wire

// ===== verif/integer_to_text_formatter_tb.sv =====
// Self-checking testbench for the integer-to-text formatter: directed table, then random requests.
`timescale 1ns / 1ps
module integer_to_text_formatter_tb;
   import itf_pkg::*;

   localparam int MAX_TEXT     = 64;
   localparam int RANDOM_ITEMS = 105;
   localparam int RSP_HOLDOFF  = 400;
   localparam int DRAIN_CYCLES = 250;
   localparam int CYCLE_LIMIT  = 400000;

   // Flag masks built from the package bit positions
   localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1) << FLAG_ZERO;
   localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1) << FLAG_SIGNED;
   localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1) << FLAG_PLUS;
   localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1) << FLAG_SPACE;
   localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1) << FLAG_LEFT;
   localparam logic [FLAGS_W-1:0] F_PREFIX = FLAGS_W'(1) << FLAG_PREFIX;
   localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1) << FLAG_LOWER;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [RADIX_W-1:0]  radix;
      logic [WIDTH_W-1:0]  text_width;
      logic [DIGITS_W-1:0] min_digits;
      logic [FLAGS_W-1:0]  format_flags;
   } fmt_request_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
      logic              bad_radix;
   } text_char_type;

   logic clock;
   logic reset;

   itf_req_if req_if ();
   itf_rsp_if rsp_if ();

   integer_to_text_formatter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   string upper_numerals = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string lower_numerals = "0123456789abcdefghijklmnopqrstuvwxyz";

   text_char_type     pending_text[$];
   logic [CHAR_W-1:0] text_buf[$];
   text_char_type     oldest;

   // Directed table: requests, typed text ("" = use the predictor), bad-base marks
   fmt_request_type dir_req[$];
   string           dir_text[$];
   bit              dir_bad[$];

   int  fail_count     = 0;
   int  chars_checked  = 0;
   int  requests_sent  = 0;
   int  bad_requests   = 0;
   int  cycle_count    = 0;
   bit  gaps_on        = 1'b1;
   bit  steady_rsp     = 1'b0;
   bit  hold_rsp       = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                  input logic [CHAR_W-1:0] want);
      $display("MISMATCH cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      fail_count++;
   endtask

   // Move the text buffer into the expected stream, capped at 64 characters
   task automatic commit_text(input bit bad);
      text_char_type item;
      int            n;
      if (bad) begin
         item.text_char = CHAR_NUL;
         item.last_char = 1'b1;
         item.bad_radix = 1'b1;
         pending_text.push_back(item);
         bad_requests++;
      end else begin
         n = (text_buf.size() > MAX_TEXT) ? MAX_TEXT : text_buf.size();
         for (int k = 0; k < n; k++) begin
            item.text_char = text_buf[k];
            item.last_char = (k == n - 1);
            item.bad_radix = 1'b0;
            pending_text.push_back(item);
         end
      end
      text_buf.delete();
   endtask

   // Format one request printf-style and queue the characters it should produce
   task automatic predict_text(input fmt_request_type r);
      logic [VALUE_W-1:0] mag;
      logic [FLAGS_W-1:0] fl;
      logic [CHAR_W-1:0]  sign_ch;
      logic [CHAR_W-1:0]  digs [DIGIT_BUFFER_DEPTH];
      int unsigned        base;
      int                 room, prec, pad, nd, pre;
      string              numerals;
      fl   = r.format_flags;
      base = r.radix;
      mag  = r.value;
      if (fl[FLAG_LEFT]) fl[FLAG_ZERO] = 1'b0;
      if (base < 2 || base > 36) begin
         commit_text(1'b1);
         return;
      end
      numerals = fl[FLAG_LOWER] ? lower_numerals : upper_numerals;
      room     = r.text_width;

      // Sign, taking the magnitude of a negative signed number
      sign_ch = CHAR_NUL;
      if (fl[FLAG_SIGNED] && mag[VALUE_BITS-1]) begin
         sign_ch = CHAR_MINUS;
         mag     = ~mag + 1'b1;
      end else if (fl[FLAG_PLUS]) begin
         sign_ch = CHAR_PLUS;
      end else if (fl[FLAG_SPACE]) begin
         sign_ch = CHAR_SPACE;
      end
      if (sign_ch != CHAR_NUL) room--;

      pre = 0;
      if (fl[FLAG_PREFIX]) begin
         if (base == 16) pre = 2;
         else if (base == 8) pre = 1;
      end
      room -= pre;

      // Digits, least significant first
      nd = 0;
      do begin
         digs[nd] = numerals[int'(mag % base)];
         nd++;
         mag = mag / base;
      end while (mag != 0 && nd < DIGIT_BUFFER_DEPTH);

      prec = (r.min_digits > nd) ? int'(r.min_digits) : nd;
      room -= prec;
      pad  = (room > 0) ? room : 0;

      // Lay out the text
      if (!fl[FLAG_ZERO] && !fl[FLAG_LEFT]) repeat (pad) text_buf.push_back(CHAR_SPACE);
      if (sign_ch != CHAR_NUL) text_buf.push_back(sign_ch);
      if (pre >= 1) text_buf.push_back(CHAR_ZERO);
      if (pre == 2) text_buf.push_back(numerals[33]);
      if (fl[FLAG_ZERO]) repeat (pad) text_buf.push_back(CHAR_ZERO);
      repeat (prec - nd) text_buf.push_back(CHAR_ZERO);
      for (int k = nd - 1; k >= 0; k--) text_buf.push_back(digs[k]);
      if (fl[FLAG_LEFT]) repeat (pad) text_buf.push_back(CHAR_SPACE);
      commit_text(1'b0);
   endtask

   // Append one row to the directed table
   task automatic add_row(input logic [VALUE_W-1:0] value, input int radix, input int width,
                          input int digits, input logic [FLAGS_W-1:0] flags,
                          input bit bad, input string text);
      fmt_request_type r;
      r.value        = value;
      r.radix        = RADIX_W'(radix);
      r.text_width   = WIDTH_W'(width);
      r.min_digits   = DIGITS_W'(digits);
      r.format_flags = flags;
      dir_req.push_back(r);
      dir_bad.push_back(bad);
      dir_text.push_back(text);
   endtask

   // Draw a random request, mostly valid bases with an emphasis on 8, 10 and 16
   function automatic fmt_request_type random_request();
      fmt_request_type r;
      int              pick;
      pick = $urandom_range(99);
      if (pick < 8)       r.radix = $urandom_range(1) ? RADIX_W'($urandom_range(1))
                                                      : RADIX_W'($urandom_range(63, 37));
      else if (pick < 30) r.radix = RADIX_HEX;
      else if (pick < 45) r.radix = RADIX_W'(10);
      else if (pick < 55) r.radix = RADIX_OCT;
      else                r.radix = RADIX_W'($urandom_range(36, 2));
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: r.value = '0;
               1: r.value = '1;
               2: r.value = {1'b1, {(VALUE_W-1){1'b0}}};
               default: r.value = {1'b0, {(VALUE_W-1){1'b1}}};
            endcase
         end
         1: r.value = VALUE_W'($urandom_range(40));
         default: r.value = $urandom;
      endcase
      r.text_width   = ($urandom_range(9) == 0) ? WIDTH_W'($urandom_range(63))
                                                : WIDTH_W'($urandom_range(16));
      r.min_digits   = ($urandom_range(9) == 0) ? DIGITS_W'($urandom_range(61))
                                                : DIGITS_W'($urandom_range(12));
      r.format_flags = FLAGS_W'($urandom_range(127));
      return r;
   endfunction

   // Offer one request, idling first at random, and return once it is taken
   task automatic offer_request(input fmt_request_type r);
      while (gaps_on && $urandom_range(99) < 36) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.value        <= r.value;
      req_if.radix        <= r.radix;
      req_if.text_width   <= r.text_width;
      req_if.min_digits   <= r.min_digits;
      req_if.format_flags <= r.format_flags;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
   endtask

   // Response side: random back-pressure, a calm stretch and one long hold-off
   initial begin
      int holdoff;
      holdoff = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            holdoff  = RSP_HOLDOFF;
         end
         if (holdoff > 0) begin
            rsp_if.ready <= 1'b0;
            holdoff--;
         end else begin
            rsp_if.ready <= steady_rsp || ($urandom_range(99) >= 36);
         end
      end
   end

   // Compare each accepted character with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         chars_checked++;
         if (pending_text.size() == 0) begin
            report_mismatch("unexpected character", rsp_if.text_char, CHAR_NUL);
         end else begin
            oldest = pending_text.pop_front();
            if (rsp_if.text_char !== oldest.text_char)
               report_mismatch("text_char", rsp_if.text_char, oldest.text_char);
            if (rsp_if.last_char !== oldest.last_char)
               report_mismatch("last_char", CHAR_W'(rsp_if.last_char), CHAR_W'(oldest.last_char));
            if (rsp_if.bad_radix !== oldest.bad_radix)
               report_mismatch("bad_radix", CHAR_W'(rsp_if.bad_radix), CHAR_W'(oldest.bad_radix));
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d characters still expected",
               cycle_count, pending_text.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Main sequence
   initial begin
      fmt_request_type r;
      string           golden;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.value        <= '0;
      req_if.radix        <= '0;
      req_if.text_width   <= '0;
      req_if.min_digits   <= '0;
      req_if.format_flags <= '0;

      // Directed table
      add_row(32'h0000_0000, 10, 0, 0, '0, 0, "0");
      add_row(32'hFFFF_FFFF, 10, 0, 0, '0, 0, "4294967295");
      add_row(32'hFFFF_FFFF, 10, 0, 0, F_SIGNED, 0, "-1");
      add_row(32'h8000_0000, 10, 0, 0, F_SIGNED, 0, "-2147483648");
      add_row(32'h7FFF_FFFF, 10, 0, 0, F_SIGNED | F_PLUS, 0, "+2147483647");
      add_row(32'h0000_0001, 0, 0, 0, '0, 1, "");
      add_row(32'h0000_0001, 1, 5, 3, F_PREFIX, 1, "");
      add_row(32'hFFFF_FFFF, 37, 63, 61, '1, 1, "");
      add_row(32'h1234_5678, 63, 0, 0, F_ZERO, 1, "");
      add_row(32'hFFFF_FFFF, 2, 0, 0, '0, 0, "");
      add_row(32'hFFFF_FFFF, 36, 0, 0, F_LOWER, 0, "");
      add_row(32'h0000_0000, 16, 0, 0, F_PREFIX, 0, "0X0");
      add_row(32'h0000_0008, 8, 0, 0, F_PREFIX, 0, "010");
      add_row(32'h0000_0005, 10, 0, 0, F_PLUS, 0, "+5");
      add_row(32'h0000_0005, 10, 0, 0, F_SPACE, 0, " 5");
      add_row(32'h0000_0001, 10, 63, 0, F_ZERO, 0, "");
      add_row(32'h8000_0000, 10, 63, 0, F_SIGNED | F_LEFT, 0, "");
      add_row(32'hFFFF_FFFF, 16, 0, 61, F_SIGNED | F_PREFIX | F_LOWER, 0, "");
      add_row(32'd42, 10, 10, 0, '0, 0, "        42");
      add_row(32'd42, 10, 6, 0, F_LEFT, 0, "42    ");
      add_row(32'd7, 10, 5, 0, F_ZERO | F_LEFT, 0, "7    ");
      add_row(32'hFFFF_FFD6, 10, 6, 0, F_SIGNED | F_ZERO, 0, "-00042");
      add_row(32'd42, 10, 0, 5, '0, 0, "00042");
      add_row(32'd35, 36, 0, 0, '0, 0, "Z");
      add_row(32'd35, 36, 0, 0, F_LOWER, 0, "z");

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < dir_req.size(); i++) begin
         offer_request(dir_req[i]);
         golden = dir_text[i];
         if (dir_bad[i] || golden.len() != 0) begin
            for (int k = 0; k < golden.len(); k++) text_buf.push_back(golden[k]);
            commit_text(dir_bad[i]);
         end else begin
            predict_text(dir_req[i]);
         end
      end

      // Random requests
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gaps_on    = !(i >= 40 && i < 70);
         steady_rsp = (i >= 40 && i < 70);
         if (i == 10) hold_rsp = 1'b1;
         if (i == 90) begin
            // hold off until the block has handed back everything
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_text.size() != 0);
         end
         r = random_request();
         offer_request(r);
         predict_text(r);
      end

      // Drain
      req_if.valid <= 1'b0;
      steady_rsp = 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_text.size() != 0) begin
         $display("MISMATCH: %0d expected characters never arrived", pending_text.size());
         fail_count++;
      end

      $display("Formatted %0d requests (%0d directed, %0d with a bad base), %0d characters checked.",
               requests_sent, dir_req.size(), bad_requests, chars_checked);
      $display("Bases 2..36, width and precision extremes, mixed flags, a long output stall, a drain pause.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== integer_to_text_formatter.f =====
src/itf_pkg.sv
src/itf_req_if.sv
src/itf_rsp_if.sv
src/itf_datapath.sv
src/itf_controller.sv
src/integer_to_text_formatter.sv
verif/integer_to_text_formatter_tb.sv
